// ===== rtl/generational_handle_table_defines.svh =====
// Assertion macros for the generational handle table checker.
// Included by the checker file only; no other dependencies.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GHT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define GHT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ght_pkg.sv =====
// Shared types, codes and helpers for the generational handle table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ght_pkg;

    // Request kinds
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
    localparam logic [1:0] FUNC_DESTROY = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // Used-bit map word geometry
    localparam int BM_BITS  = 32;
    localparam int BM_OFF_W = 5;
    localparam int BM_GRP   = 8;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  handle_index;
        logic [31:0] handle_generation;
        logic [31:0] new_tex_slot;
        logic [14:0] new_width;
        logic [14:0] new_height;
    } ght_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_index;
        logic [31:0] out_generation;
        logic [31:0] out_tex_slot;
        logic [14:0] out_width;
        logic [14:0] out_height;
    } ght_rsp_t;

    // One slot of the entry memory
    typedef struct packed {
        logic [31:0] gen;
        logic [31:0] tex;
        logic [14:0] width;
        logic [14:0] height;
    } ght_entry_t;

    // Lowest clear bit of a map word
    typedef struct packed {
        logic                found;
        logic [BM_OFF_W-1:0] pos;
    } ght_zpos_t;

    typedef enum logic [1:0] {
        GHT_IDLE,
        GHT_READ,
        GHT_CHECK,
        GHT_ALLOC
    } ght_state_t;

    // Advance a generation, skipping zero on wrap
    function automatic logic [31:0] ght_next_gen(input logic [31:0] g);
        logic [31:0] n;
        n = g + 32'd1;
        return (n == 32'd0) ? 32'd1 : n;
    endfunction

endpackage

// ===== rtl/ght_first_zero.sv =====
// Two-level priority encoder: lowest clear bit of one used-bit map word.
// Depends on ght_pkg for the word geometry and the result type.
`timescale 1ns / 1ps

module ght_first_zero (
    input  logic [ght_pkg::BM_BITS-1:0] bits,
    output ght_pkg::ght_zpos_t          zpos
);
    import ght_pkg::*;

    localparam int NGRP  = BM_BITS / BM_GRP;
    localparam int GPOS_W = $clog2(BM_GRP);

    logic [NGRP-1:0]   grp_found;
    logic [GPOS_W-1:0] grp_pos [NGRP];

    // Find the lowest clear bit inside each byte
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_found[g] = 1'b0;
            grp_pos[g]   = '0;
            for (int b = BM_GRP - 1; b >= 0; b--) begin
                if (!bits[g*BM_GRP + b]) begin
                    grp_found[g] = 1'b1;
                    grp_pos[g]   = GPOS_W'(b);
                end
            end
        end
    end

    // Pick the lowest byte that has one
    always_comb begin
        zpos = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_found[g]) begin
                zpos.found = 1'b1;
                zpos.pos   = BM_OFF_W'(g*BM_GRP) + BM_OFF_W'(grp_pos[g]);
            end
        end
    end

endmodule

// ===== rtl/generational_handle_table.sv =====
// Generational handle table: one request in flight, result held in an output register.
// Lookup, destroy and failed allocate go READ then CHECK; a good allocate adds ALLOC.
// The last state waits while the output register is full. A new request is taken only once
// the read-modify-write of entry memory and map word (one read, at most one write-back) ends.
// Reset is synchronous and clears control only; no clearing pass runs. A fill mark makes
// slots never allocated read as free with generation zero, so requests are taken at once.
`timescale 1ns / 1ps

module generational_handle_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ght_pkg::ght_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ght_pkg::ght_rsp_t m_data
);
    import ght_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int WORDS  = (TABLE_ENTRIES + BM_BITS - 1) / BM_BITS;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W = WA_W + BM_OFF_W;
    localparam int SX_W   = SLOT_W + 1;
    localparam int HX_W   = ((SLOT_W > 8) ? SLOT_W : 8) + 1;
    localparam int HM_W   = $clog2(TABLE_ENTRIES + 1);

    // Control and request registers
    ght_state_t        state_reg, state_next;
    ght_req_t          req_reg, req_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              any_free_reg, any_free_next;
    logic [HM_W-1:0]   high_mark_reg, high_mark_next;
    logic [WORDS-1:0]  has_free_reg, has_free_next;
    logic              m_valid_reg, m_valid_next;
    ght_rsp_t          m_data_reg, m_data_next;

    // Memories and their ports
    logic [BM_BITS-1:0] bm_mem [WORDS];
    logic [BM_BITS-1:0] bm_rdata_reg;
    ght_entry_t         ent_mem [TABLE_ENTRIES];
    ght_entry_t         ent_rdata_reg;

    logic               bm_rd_en, bm_wr_en;
    logic [WA_W-1:0]    bm_rd_addr;
    logic [BM_BITS-1:0] bm_wr_data;
    logic               ent_rd_en, ent_wr_en;
    logic [IDX_W-1:0]   ent_rd_addr;
    ght_entry_t         ent_wr_data;

    // Datapath signals
    logic [HX_W-1:0]    hidx_ext;
    logic [SLOT_W-1:0]  hslot;
    logic               range_ok;
    logic [WA_W-1:0]    free_word;
    logic               any_free;
    logic [WA_W-1:0]    cur_word;
    logic [BM_BITS-1:0] live_bits, taken_bits, sel_bit;
    ght_zpos_t          zpos;
    logic [SLOT_W-1:0]  alloc_slot;
    logic               below_mark;
    logic [31:0]        old_gen;
    logic               handle_ok;
    logic               out_free;

    assign s_ready  = (state_reg == GHT_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Decode the request handle
    assign hidx_ext = HX_W'(req_reg.handle_index);
    assign hslot    = hidx_ext[SLOT_W-1:0];
    assign range_ok = (hidx_ext != '0) && (hidx_ext < HX_W'(TABLE_ENTRIES));

    // Lowest map word that still holds a free slot
    always_comb begin
        free_word = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (has_free_reg[i]) begin
                free_word = WA_W'(i);
            end
        end
    end
    assign any_free = |has_free_reg;

    // Mask the map word: bits at or past the fill mark were never written
    assign cur_word = slot_reg[SLOT_W-1:BM_OFF_W];
    always_comb begin
        logic [SX_W-1:0] slot_b;
        for (int b = 0; b < BM_BITS; b++) begin
            slot_b        = {1'b0, cur_word, BM_OFF_W'(b)};
            live_bits[b]  = bm_rdata_reg[b] && (slot_b < SX_W'(high_mark_reg));
            taken_bits[b] = live_bits[b] || (slot_b == '0) ||
                            (slot_b >= SX_W'(TABLE_ENTRIES));
        end
    end

    ght_first_zero u_first_zero (
        .bits (taken_bits),
        .zpos (zpos)
    );

    assign alloc_slot = {cur_word, zpos.pos};
    assign sel_bit    = BM_BITS'(1) << slot_reg[BM_OFF_W-1:0];
    assign below_mark = (SX_W'(slot_reg) < SX_W'(high_mark_reg));
    assign old_gen    = below_mark ? ent_rdata_reg.gen : 32'd0;
    assign handle_ok  = range_ok &&
                        ((req_reg.func == FUNC_LOOKUP) || (req_reg.func == FUNC_DESTROY)) &&
                        live_bits[slot_reg[BM_OFF_W-1:0]] &&
                        (ent_rdata_reg.gen == req_reg.handle_generation);

    // Sequencer: next state, memory requests and result
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        any_free_next  = any_free_reg;
        high_mark_next = high_mark_reg;
        has_free_next  = has_free_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        bm_rd_en       = 1'b0;
        bm_rd_addr     = '0;
        bm_wr_en       = 1'b0;
        bm_wr_data     = live_bits;
        ent_rd_en      = 1'b0;
        ent_rd_addr    = '0;
        ent_wr_en      = 1'b0;
        ent_wr_data    = ent_rdata_reg;

        unique case (state_reg)
            GHT_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = GHT_READ;
                end
            end
            GHT_READ: begin
                any_free_next = any_free;
                if (req_reg.func == FUNC_ALLOC) begin
                    bm_rd_en   = 1'b1;
                    bm_rd_addr = free_word;
                    slot_next  = {free_word, BM_OFF_W'(0)};
                end else begin
                    slot_next = hslot;
                    if (range_ok) begin
                        bm_rd_en    = 1'b1;
                        bm_rd_addr  = hslot[SLOT_W-1:BM_OFF_W];
                        ent_rd_en   = 1'b1;
                        ent_rd_addr = hslot[IDX_W-1:0];
                    end
                end
                state_next = GHT_CHECK;
            end
            GHT_CHECK: begin
                if ((req_reg.func == FUNC_ALLOC) && any_free_reg) begin
                    // fetch the old generation of the chosen slot
                    slot_next   = alloc_slot;
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = alloc_slot[IDX_W-1:0];
                    state_next  = GHT_ALLOC;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    if (req_reg.func == FUNC_ALLOC) begin
                        m_data_next.status = STATUS_FULL;
                    end else if (handle_ok) begin
                        m_data_next.status         = STATUS_OK;
                        m_data_next.out_index      = req_reg.handle_index;
                        m_data_next.out_generation = req_reg.handle_generation;
                        m_data_next.out_tex_slot   = ent_rdata_reg.tex;
                        if (req_reg.func == FUNC_LOOKUP) begin
                            m_data_next.out_width  = ent_rdata_reg.width;
                            m_data_next.out_height = ent_rdata_reg.height;
                        end else begin
                            // free the slot and retire every handle to it
                            ent_wr_en               = 1'b1;
                            ent_wr_data.gen         = ght_next_gen(ent_rdata_reg.gen);
                            bm_wr_en                = 1'b1;
                            bm_wr_data              = live_bits & ~sel_bit;
                            has_free_next[cur_word] = 1'b1;
                        end
                    end else begin
                        m_data_next.status = STATUS_BAD;
                    end
                    state_next = GHT_IDLE;
                end
            end
            GHT_ALLOC: begin
                if (out_free) begin
                    ent_wr_en               = 1'b1;
                    ent_wr_data.gen         = ght_next_gen(old_gen);
                    ent_wr_data.tex         = req_reg.new_tex_slot;
                    ent_wr_data.width       = req_reg.new_width;
                    ent_wr_data.height      = req_reg.new_height;
                    bm_wr_en                = 1'b1;
                    bm_wr_data              = live_bits | sel_bit;
                    has_free_next[cur_word] = |(~(taken_bits | sel_bit));
                    if (!below_mark) begin
                        high_mark_next = HM_W'(SX_W'(slot_reg) + SX_W'(1));
                    end
                    m_valid_next               = 1'b1;
                    m_data_next                = '0;
                    m_data_next.status         = STATUS_OK;
                    m_data_next.out_index      = 8'(slot_reg);
                    m_data_next.out_generation = ght_next_gen(old_gen);
                    state_next                 = GHT_IDLE;
                end
            end
            default: begin
                state_next = GHT_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= GHT_IDLE;
            high_mark_reg <= HM_W'(1);
            has_free_reg  <= '1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            high_mark_reg <= high_mark_next;
            has_free_reg  <= has_free_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        slot_reg     <= slot_next;
        any_free_reg <= any_free_next;
        m_data_reg   <= m_data_next;
    end

    // Used-bit map memory; writes only ever target the word read for this request
    always_ff @(posedge aclk) begin
        if (bm_wr_en) begin
            bm_mem[cur_word] <= bm_wr_data;
        end
        if (bm_rd_en) begin
            bm_rdata_reg <= bm_mem[bm_rd_addr];
        end
    end

    // Entry memory: generation and payload per slot
    always_ff @(posedge aclk) begin
        if (ent_wr_en) begin
            ent_mem[slot_reg[IDX_W-1:0]] <= ent_wr_data;
        end
        if (ent_rd_en) begin
            ent_rdata_reg <= ent_mem[ent_rd_addr];
        end
    end

endmodule

// ===== rtl/ght_checker.sv =====
// Port-level checks for the generational handle table, bound to the top level.
// Depends on ght_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "generational_handle_table_defines.svh"

module ght_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ght_pkg::ght_rsp_t m_data
);
    import ght_pkg::*;

    // Hold a stalled result
    `GHT_ASSERT_NXT(a_rsp_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    // Accept no new request while one is in flight
    `GHT_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while busy")

    // Status carries a defined code
    `GHT_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, (m_data.status == STATUS_OK) || (m_data.status == STATUS_FULL) || (m_data.status == STATUS_BAD), "undefined status code")

    // Failures clear every other field
    `GHT_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_valid && (m_data.status != STATUS_OK), (m_data.out_index == 8'd0) && (m_data.out_generation == 32'd0) && (m_data.out_tex_slot == 32'd0) && (m_data.out_width == 15'd0) && (m_data.out_height == 15'd0), "failure result not cleared")

    // A good handle never has generation zero
    `GHT_ASSERT_IMP(a_ok_gen, aclk, aresetn, m_valid && (m_data.status == STATUS_OK), m_data.out_generation != 32'd0, "ok result with zero generation")

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);
